@@ hw/rtl/assert_macros.svh @@
// assertion helpers included by the top-level text store rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled during reset
`define AST_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    `AST_CLK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
    `AST_CLK(lbl, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/gbts_pkg.sv @@
// ----------------------------------------------------------------------------
// gbts_pkg
// shared constants, command codes and controller/datapath types for the
// gap buffer text store
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 2);
    localparam int TW = 13;
    localparam int WW = (PW > TW) ? PW : TW;

    typedef logic [PW-1:0] t_pos;

    localparam logic [7:0] NEWLINE = 8'h0A;

    // command codes
    localparam logic [3:0] CMD_INS       = 4'd0;
    localparam logic [3:0] CMD_BKSP      = 4'd1;
    localparam logic [3:0] CMD_DEL       = 4'd2;
    localparam logic [3:0] CMD_LEFT      = 4'd3;
    localparam logic [3:0] CMD_RIGHT     = 4'd4;
    localparam logic [3:0] CMD_GOTOPOS   = 4'd5;
    localparam logic [3:0] CMD_LINESTART = 4'd6;
    localparam logic [3:0] CMD_LINEEND   = 4'd7;
    localparam logic [3:0] CMD_UP        = 4'd8;
    localparam logic [3:0] CMD_DOWN      = 4'd9;
    localparam logic [3:0] CMD_GOTOLINE  = 4'd10;
    localparam logic [3:0] CMD_READ      = 4'd11;
    localparam logic [3:0] CMD_LOCATE    = 4'd12;
    localparam logic [3:0] CMD_CLRMOD    = 4'd13;

    // result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_IGN    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    // datapath micro operations
    typedef logic [4:0] t_dp_op;
    localparam t_dp_op OP_NOP    = 5'd0;
    localparam t_dp_op OP_LATCH  = 5'd1;
    localparam t_dp_op OP_IGN    = 5'd2;
    localparam t_dp_op OP_FULL   = 5'd3;
    localparam t_dp_op OP_BEYOND = 5'd4;
    localparam t_dp_op OP_INS    = 5'd5;
    localparam t_dp_op OP_BKSP   = 5'd6;
    localparam t_dp_op OP_DEL    = 5'd7;
    localparam t_dp_op OP_CLR    = 5'd8;
    localparam t_dp_op OP_A_INIT = 5'd9;
    localparam t_dp_op OP_B_INIT = 5'd10;
    localparam t_dp_op OP_RD     = 5'd11;
    localparam t_dp_op OP_EV_A   = 5'd12;
    localparam t_dp_op OP_EV_B   = 5'd13;
    localparam t_dp_op OP_TGT    = 5'd14;
    localparam t_dp_op OP_ML_RD  = 5'd15;
    localparam t_dp_op OP_ML_WR  = 5'd16;
    localparam t_dp_op OP_MR_RD  = 5'd17;
    localparam t_dp_op OP_MR_WR  = 5'd18;
    localparam t_dp_op OP_RB_RD  = 5'd19;
    localparam t_dp_op OP_RB_CAP = 5'd20;

    // datapath status seen by the controller
    typedef struct packed {
        logic [3:0] cmd;
        logic       full;
        logic       at_start;
        logic       at_end;
        logic       scan_end;
        logic       b_done;
        logic       li_zero;
        logic       on_last;
        logic       mv_left;
        logic       mv_right;
        logic       rd_beyond;
    } t_dp_stat;

endpackage

@@ hw/rtl/gap_buffer_text_store.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// text store of CAPACITY bytes kept as a gap buffer with the cursor at the gap
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result has been shown. The result is on the o_ ports for one
// cycle with o_done high, and the receiver cannot stall it. Insert, backspace,
// delete, clear and status-only answers go through the idle, dispatch and done
// states; a read adds a memory read and a capture state before done. Cursor
// moves take a position compare, then a read and a write on the single memory
// port, for each byte the gap travels. Line commands other than goto-line
// first walk the whole text for the cursor line; all but line-start and locate
// then walk up to the end of the wanted line, and all but locate then move the
// gap. No clearing pass is run after reset.
module gap_buffer_text_store
    import gbts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [3:0]    i_cmd,
    input  logic [7:0]    i_char_in,
    input  logic [12:0]   i_target,
    output logic          o_done,
    output logic [1:0]    o_status,
    output logic [12:0]   o_cursor,
    output logic [12:0]   o_text_length,
    output logic [7:0]    o_byte_out,
    output logic [12:0]   o_line_no,
    output logic [12:0]   o_col_no,
    output logic [12:0]   o_line_total,
    output logic          o_dirty
);

`include "assert_macros.svh"

    t_dp_op   w_op;
    t_dp_stat w_stat;

    // sequencer
    gbts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // memory and registers
    gbts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_cmd         (i_cmd),
        .i_char_in     (i_char_in),
        .i_target      (i_target),
        .o_stat        (w_stat),
        .o_status      (o_status),
        .o_cursor      (o_cursor),
        .o_text_length (o_text_length),
        .o_byte_out    (o_byte_out),
        .o_line_no     (o_line_no),
        .o_col_no      (o_col_no),
        .o_line_total  (o_line_total),
        .o_dirty       (o_dirty)
    );

    // checks
    `AST_NXT(a_accept_busy, start && !busy, busy && !o_done, "accepted transaction not busy")
    `AST_NXT(a_done_once, o_done, !o_done && !busy, "result strobe longer than one cycle")
    `AST_IMP(a_cursor_in_text, o_done, o_cursor <= o_text_length, "cursor beyond text end")
    `AST_IMP(a_len_cap, o_done, o_text_length <= 13'(CAPACITY), "text length above capacity")

endmodule

@@ hw/rtl/gbts_dp.sv @@
// ----------------------------------------------------------------------------
// gbts_dp
// datapath: text memory, gap pointers, scan counters and result registers
// ----------------------------------------------------------------------------
module gbts_dp
    import gbts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_op        i_op,
    input  logic [3:0]    i_cmd,
    input  logic [7:0]    i_char_in,
    input  logic [TW-1:0] i_target,
    output t_dp_stat      o_stat,
    output logic [1:0]    o_status,
    output logic [TW-1:0] o_cursor,
    output logic [TW-1:0] o_text_length,
    output logic [7:0]    o_byte_out,
    output logic [TW-1:0] o_line_no,
    output logic [TW-1:0] o_col_no,
    output logic [TW-1:0] o_line_total,
    output logic          o_dirty
);

    logic [7:0]    r_mem [CAPACITY];
    logic [7:0]    r_rdata;
    logic [3:0]    r_cmd;
    logic [7:0]    r_char;
    logic [TW-1:0] r_tgt;
    t_pos          r_lo, r_hi, r_p, r_nl, r_li, r_ls, r_tot, r_idx, r_s, r_e, r_mt;
    logic          r_dirty, r_found, r_bdone;
    logic [1:0]    r_status;
    logic [7:0]    r_byte;

    t_pos          w_gap, w_len, w_tp, w_pa, w_ta, w_s, w_e, w_l, w_col, w_cc, w_mt, w_idx;
    logic [WW-1:0] w_tgt_w, w_len_w;
    logic          w_nl;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [7:0]    w_wdata;

    // lengths and logical-to-physical mapping
    assign w_gap   = r_hi - r_lo;
    assign w_len   = t_pos'(CAPACITY) - w_gap;
    assign w_tgt_w = WW'(r_tgt);
    assign w_len_w = WW'(w_len);
    assign w_tp    = t_pos'(r_tgt);
    assign w_pa    = (r_p < r_lo) ? r_p : r_p + w_gap;
    assign w_ta    = (w_tp < r_lo) ? w_tp : w_tp + w_gap;
    assign w_nl    = (r_rdata == NEWLINE);

    // line bounds found by the second pass, text end when not found
    assign w_s   = r_found ? r_s : w_len;
    assign w_e   = r_bdone ? r_e : w_len;
    assign w_l   = w_e - w_s;
    assign w_col = r_lo - r_ls;
    assign w_cc  = (w_col < w_l) ? w_col : w_l;

    // gap move target per command
    always_comb begin
        case (r_cmd)
            CMD_LEFT:      w_mt = r_lo - t_pos'(1);
            CMD_RIGHT:     w_mt = r_lo + t_pos'(1);
            CMD_GOTOPOS:   w_mt = (w_tgt_w < w_len_w) ? w_tp : w_len;
            CMD_LINESTART: w_mt = r_ls;
            CMD_LINEEND:   w_mt = w_e;
            CMD_UP,
            CMD_DOWN:      w_mt = w_s + w_cc;
            CMD_GOTOLINE:  w_mt = w_s;
            default:       w_mt = r_lo;
        endcase
    end

    // line index searched by the second pass
    always_comb begin
        case (r_cmd)
            CMD_LINEEND: w_idx = r_li;
            CMD_UP:      w_idx = r_li - t_pos'(1);
            CMD_DOWN:    w_idx = r_li + t_pos'(1);
            default: begin
                if (w_tgt_w == '0) begin
                    w_idx = '0;
                end else if (w_tgt_w - WW'(1) > WW'(CAPACITY + 1)) begin
                    w_idx = t_pos'(CAPACITY + 1);
                end else begin
                    w_idx = t_pos'(w_tgt_w - WW'(1));
                end
            end
        endcase
    end

    // memory address and write control
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_rdata;
        case (i_op)
            OP_RB_RD: w_addr = w_ta[AW-1:0];
            OP_ML_RD: w_addr = AW'(r_lo - t_pos'(1));
            OP_ML_WR: begin
                w_addr = AW'(r_hi - t_pos'(1));
                w_we   = 1'b1;
            end
            OP_MR_RD: w_addr = r_hi[AW-1:0];
            OP_MR_WR: begin
                w_addr = r_lo[AW-1:0];
                w_we   = 1'b1;
            end
            OP_INS: begin
                w_addr  = r_lo[AW-1:0];
                w_we    = 1'b1;
                w_wdata = r_char;
            end
            default:  w_addr = w_pa[AW-1:0];
        endcase
    end

    // text memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    // gap pointers and dirty flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= '0;
            r_hi    <= t_pos'(CAPACITY);
            r_dirty <= 1'b0;
        end else begin
            case (i_op)
                OP_INS: begin
                    r_lo    <= r_lo + t_pos'(1);
                    r_dirty <= 1'b1;
                end
                OP_BKSP: begin
                    r_lo    <= r_lo - t_pos'(1);
                    r_dirty <= 1'b1;
                end
                OP_DEL: begin
                    r_hi    <= r_hi + t_pos'(1);
                    r_dirty <= 1'b1;
                end
                OP_CLR:   r_dirty <= 1'b0;
                OP_ML_WR: begin
                    r_lo <= r_lo - t_pos'(1);
                    r_hi <= r_hi - t_pos'(1);
                end
                OP_MR_WR: begin
                    r_lo <= r_lo + t_pos'(1);
                    r_hi <= r_hi + t_pos'(1);
                end
                default: ;
            endcase
        end
    end

    // transaction payload, scan counters and result registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                r_cmd    <= i_cmd;
                r_char   <= i_char_in;
                r_tgt    <= i_target;
                r_status <= ST_DONE;
                r_byte   <= '0;
            end
            OP_IGN:    r_status <= ST_IGN;
            OP_FULL:   r_status <= ST_FULL;
            OP_BEYOND: r_status <= ST_BEYOND;
            OP_A_INIT: begin
                r_p   <= '0;
                r_li  <= '0;
                r_ls  <= '0;
                r_tot <= '0;
            end
            OP_EV_A: begin
                r_p <= r_p + t_pos'(1);
                if (w_nl) begin
                    r_tot <= r_tot + t_pos'(1);
                    if (r_p < r_lo) begin
                        r_li <= r_li + t_pos'(1);
                        r_ls <= r_p + t_pos'(1);
                    end
                end
            end
            OP_B_INIT: begin
                r_p     <= '0;
                r_nl    <= '0;
                r_idx   <= w_idx;
                r_found <= (w_idx == '0);
                r_s     <= '0;
                r_e     <= '0;
                r_bdone <= 1'b0;
            end
            OP_EV_B: begin
                r_p <= r_p + t_pos'(1);
                if (w_nl) begin
                    if (!r_found) begin
                        r_nl <= r_nl + t_pos'(1);
                        if (r_nl + t_pos'(1) == r_idx) begin
                            r_found <= 1'b1;
                            r_s     <= r_p + t_pos'(1);
                        end
                    end else begin
                        r_e     <= r_p;
                        r_bdone <= 1'b1;
                    end
                end
            end
            OP_TGT:    r_mt   <= w_mt;
            OP_RB_CAP: r_byte <= r_rdata;
            default: ;
        endcase
    end

    // status toward the controller
    assign o_stat.cmd       = r_cmd;
    assign o_stat.full      = (w_len == t_pos'(CAPACITY));
    assign o_stat.at_start  = (r_lo == '0);
    assign o_stat.at_end    = (r_hi == t_pos'(CAPACITY));
    assign o_stat.scan_end  = (r_p == w_len);
    assign o_stat.b_done    = r_bdone;
    assign o_stat.li_zero   = (r_li == '0);
    assign o_stat.on_last   = (r_li == r_tot);
    assign o_stat.mv_left   = (r_lo > r_mt);
    assign o_stat.mv_right  = (r_lo < r_mt);
    assign o_stat.rd_beyond = (w_tgt_w >= w_len_w);

    // result fields
    assign o_status      = r_status;
    assign o_cursor      = TW'(r_lo);
    assign o_text_length = TW'(w_len);
    assign o_byte_out    = r_byte;
    assign o_line_no     = (r_cmd == CMD_LOCATE) ? TW'(r_li + t_pos'(1)) : '0;
    assign o_col_no      = (r_cmd == CMD_LOCATE) ? TW'(w_col + t_pos'(1)) : '0;
    assign o_line_total  = (r_cmd == CMD_LOCATE) ? TW'(r_tot + t_pos'(1)) : '0;
    assign o_dirty       = r_dirty;

endmodule

@@ hw/rtl/gbts_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbts_ctrl
// command sequencer: dispatches commands, runs line scans and gap moves
// ----------------------------------------------------------------------------
module gbts_ctrl
    import gbts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_done,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_A_RD   = 4'd2;
    localparam logic [3:0] S_A_EV   = 4'd3;
    localparam logic [3:0] S_A_CHK  = 4'd4;
    localparam logic [3:0] S_B_RD   = 4'd5;
    localparam logic [3:0] S_B_EV   = 4'd6;
    localparam logic [3:0] S_TGT    = 4'd7;
    localparam logic [3:0] S_MV     = 4'd8;
    localparam logic [3:0] S_L_RD   = 4'd9;
    localparam logic [3:0] S_L_WR   = 4'd10;
    localparam logic [3:0] S_R_RD   = 4'd11;
    localparam logic [3:0] S_R_WR   = 4'd12;
    localparam logic [3:0] S_RB_RD  = 4'd13;
    localparam logic [3:0] S_RB_CAP = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0] r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath operation
    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_LATCH;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                unique case (i_stat.cmd) inside
                    CMD_INS:    o_op = i_stat.full ? OP_FULL : OP_INS;
                    CMD_BKSP:   o_op = i_stat.at_start ? OP_IGN : OP_BKSP;
                    CMD_DEL:    o_op = i_stat.at_end ? OP_IGN : OP_DEL;
                    CMD_LEFT: begin
                        if (i_stat.at_start) o_op = OP_IGN;
                        else n_state = S_TGT;
                    end
                    CMD_RIGHT: begin
                        if (i_stat.at_end) o_op = OP_IGN;
                        else n_state = S_TGT;
                    end
                    CMD_GOTOPOS: n_state = S_TGT;
                    CMD_LINESTART, CMD_LINEEND, CMD_UP, CMD_DOWN, CMD_LOCATE: begin
                        o_op    = OP_A_INIT;
                        n_state = S_A_RD;
                    end
                    CMD_GOTOLINE: begin
                        o_op    = OP_B_INIT;
                        n_state = S_B_RD;
                    end
                    CMD_READ: begin
                        if (i_stat.rd_beyond) o_op = OP_BEYOND;
                        else n_state = S_RB_RD;
                    end
                    CMD_CLRMOD: o_op = OP_CLR;
                    default:    o_op = OP_IGN;
                endcase
            end
            // whole-text pass: cursor line, line start, newline total
            S_A_RD: begin
                if (i_stat.scan_end) begin
                    n_state = S_A_CHK;
                end else begin
                    o_op    = OP_RD;
                    n_state = S_A_EV;
                end
            end
            S_A_EV: begin
                o_op    = OP_EV_A;
                n_state = S_A_RD;
            end
            S_A_CHK: begin
                unique case (i_stat.cmd) inside
                    CMD_LINESTART: n_state = S_TGT;
                    CMD_LOCATE:    n_state = S_DONE;
                    CMD_UP: begin
                        if (i_stat.li_zero) begin
                            o_op    = OP_IGN;
                            n_state = S_DONE;
                        end else begin
                            o_op    = OP_B_INIT;
                            n_state = S_B_RD;
                        end
                    end
                    CMD_DOWN: begin
                        if (i_stat.on_last) begin
                            o_op    = OP_IGN;
                            n_state = S_DONE;
                        end else begin
                            o_op    = OP_B_INIT;
                            n_state = S_B_RD;
                        end
                    end
                    default: begin
                        o_op    = OP_B_INIT;
                        n_state = S_B_RD;
                    end
                endcase
            end
            // line search pass: start and end of the wanted line
            S_B_RD: begin
                if (i_stat.scan_end || i_stat.b_done) begin
                    n_state = S_TGT;
                end else begin
                    o_op    = OP_RD;
                    n_state = S_B_EV;
                end
            end
            S_B_EV: begin
                o_op    = OP_EV_B;
                n_state = S_B_RD;
            end
            S_TGT: begin
                o_op    = OP_TGT;
                n_state = S_MV;
            end
            // gap move, one byte per read/write pair
            S_MV: begin
                if (i_stat.mv_left) n_state = S_L_RD;
                else if (i_stat.mv_right) n_state = S_R_RD;
                else n_state = S_DONE;
            end
            S_L_RD: begin
                o_op    = OP_ML_RD;
                n_state = S_L_WR;
            end
            S_L_WR: begin
                o_op    = OP_ML_WR;
                n_state = S_MV;
            end
            S_R_RD: begin
                o_op    = OP_MR_RD;
                n_state = S_R_WR;
            end
            S_R_WR: begin
                o_op    = OP_MR_WR;
                n_state = S_MV;
            end
            S_RB_RD: begin
                o_op    = OP_RB_RD;
                n_state = S_RB_CAP;
            end
            S_RB_CAP: begin
                o_op    = OP_RB_CAP;
                n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
